// File: sv/stereo_dual_nco_tone_generator_top_macros.svh
`ifndef STEREO_DUAL_NCO_TONE_GENERATOR_TOP_MACROS_SVH
`define STEREO_DUAL_NCO_TONE_GENERATOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define SDNCO_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sdnco: same-cycle check failed");
`define SDNCO_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sdnco: next-cycle check failed");
`else
`define SDNCO_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define SDNCO_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif
`endif

// File: sv/sdnco_pkg.sv
package sdnco_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 31;

    localparam logic [CFG_INDEX_W-1:0] CFG_LEFT_STEP   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RIGHT_STEP  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WAVE_SEL    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_TONE_MODE   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_AMPLITUDE   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOOP_FRAMES = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_FADE_FRAMES = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_FADE_STEP   = 3'd7;

    localparam logic [1:0] WAVE_SINE     = 2'd0;
    localparam logic [1:0] WAVE_SQUARE   = 2'd1;
    localparam logic [1:0] WAVE_TRIANGLE = 2'd2;
    localparam logic [1:0] WAVE_SAWTOOTH = 2'd3;

    typedef logic [1:0] t_op;
    localparam t_op OP_GAIN = 2'd0;
    localparam t_op OP_AMP  = 2'd1;
    localparam t_op OP_FIN  = 2'd2;
    localparam t_op OP_FOUT = 2'd3;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned FULL_SCALE  = 64'd32767;

    typedef struct packed {
        logic [30:0] left_step;
        logic [30:0] right_step;
        logic [1:0]  wave_sel;
        logic        tone_mode;
        logic [15:0] amplitude;
        logic [25:0] loop_frames;
        logic [15:0] fade_frames;
        logic [16:0] fade_step;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        left_step:   31'd35058241,
        right_step:  31'd35820753,
        wave_sel:    WAVE_SINE,
        tone_mode:   1'b0,
        amplitude:   16'd16384,
        loop_frames: 26'd13230000,
        fade_frames: 16'd1102,
        fade_step:   17'd59
    };

    typedef struct packed {
        logic load;
        logic run;
        t_op  op;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic        neg;
        logic [14:0] mag;
    } t_wave;

    // Quarter-wave sine entry in units of 1/32767 for angle x in Q30.
    function automatic logic [14:0] sine_entry(input longint unsigned x);
        longint unsigned x2;
        longint unsigned term;
        longint unsigned v;
        longint          sum;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        term = (term * x2) >> 30;
        term = term / 6;
        sum  = sum - longint'(term);
        term = (term * x2) >> 30;
        term = term / 20;
        sum  = sum + longint'(term);
        term = (term * x2) >> 30;
        term = term / 42;
        sum  = sum - longint'(term);
        term = (term * x2) >> 30;
        term = term / 72;
        sum  = sum + longint'(term);
        term = (term * x2) >> 30;
        term = term / 110;
        sum  = sum - longint'(term);
        term = (term * x2) >> 30;
        term = term / 156;
        sum  = sum + longint'(term);
        term = (term * x2) >> 30;
        term = term / 210;
        sum  = sum - longint'(term);
        term = (term * x2) >> 30;
        term = term / 272;
        sum  = sum + longint'(term);
        if (sum < 0) begin
            sum = 0;
        end
        v = ($unsigned(sum) * FULL_SCALE + (64'd1 << 29)) >> 30;
        if (v > FULL_SCALE) begin
            v = FULL_SCALE;
        end
        return v[14:0];
    endfunction

endpackage

// File: sv/sdnco_cfg.sv
module sdnco_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    input  logic [sdnco_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [sdnco_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output sdnco_pkg::t_cfg                    o_cfg
);
    import sdnco_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LEFT_STEP:   r_cfg.left_step   <= i_cfg_data[30:0];
                CFG_RIGHT_STEP:  r_cfg.right_step  <= i_cfg_data[30:0];
                CFG_WAVE_SEL:    r_cfg.wave_sel    <= i_cfg_data[1:0];
                CFG_TONE_MODE:   r_cfg.tone_mode   <= i_cfg_data[0];
                CFG_AMPLITUDE:   r_cfg.amplitude   <= i_cfg_data[15:0];
                CFG_LOOP_FRAMES: r_cfg.loop_frames <= i_cfg_data[25:0];
                CFG_FADE_FRAMES: r_cfg.fade_frames <= i_cfg_data[15:0];
                CFG_FADE_STEP:   r_cfg.fade_step   <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: sv/sdnco_ctrl.sv
module sdnco_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic            i_out_ready,
    output logic            o_out_valid,
    output sdnco_pkg::t_cmd o_cmd
);
    import sdnco_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_GAIN = 3'd1;
    localparam logic [2:0] ST_AMP  = 3'd2;
    localparam logic [2:0] ST_FIN  = 3'd3;
    localparam logic [2:0] ST_FOUT = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       w_finish;
    logic       w_accept;

    assign w_finish   = (r_state == ST_FOUT) && (!r_out_valid || i_out_ready);
    assign o_in_ready = (r_state == ST_IDLE) || w_finish;
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_accept) n_state = ST_GAIN;
            ST_GAIN: n_state = ST_AMP;
            ST_AMP:  n_state = ST_FIN;
            ST_FIN:  n_state = ST_FOUT;
            ST_FOUT: begin
                if (w_finish) begin
                    n_state = w_accept ? ST_GAIN : ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_finish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        o_cmd.load   = w_accept;
        o_cmd.run    = (r_state != ST_IDLE);
        o_cmd.finish = w_finish;
        unique case (r_state)
            ST_AMP:  o_cmd.op = OP_AMP;
            ST_FIN:  o_cmd.op = OP_FIN;
            ST_FOUT: o_cmd.op = OP_FOUT;
            default: o_cmd.op = OP_GAIN;
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

// File: sv/sdnco_wave.sv
module sdnco_wave #(
    parameter int PHASE_BITS       = 32,
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic [PHASE_BITS-1:0]                   i_phase,
    input  logic [1:0]                              i_wave_sel,
    input  logic                                    i_unipolar,
    input  logic [14:0]                             i_rom_data,
    output logic [$clog2(SINE_TABLE_DEPTH+1)-1:0]   o_rom_addr,
    output sdnco_pkg::t_wave                        o_wave
);
    import sdnco_pkg::*;

    localparam int QB = PHASE_BITS - 2;
    localparam int IW = $clog2(SINE_TABLE_DEPTH + 1);
    localparam logic [IW-1:0] DEPTH_W = IW'(SINE_TABLE_DEPTH);

    logic [QB+IW-1:0]   w_idx_prod;
    logic [IW-1:0]      w_idx;
    logic [1:0]         w_quad;
    logic [15:0]        w_u;
    logic [18:0]        w_u4;
    logic [18:0]        w_u2;
    logic signed [18:0] w_t;
    logic [16:0]        w_tmag;
    logic [31:0]        w_scaled;
    logic               w_first_half;

    assign w_quad     = i_phase[PHASE_BITS-1:PHASE_BITS-2];
    assign w_idx_prod = (QB+IW)'(i_phase[QB-1:0]) * (QB+IW)'(SINE_TABLE_DEPTH);
    assign w_idx      = w_idx_prod[QB+IW-1:QB];
    assign o_rom_addr = w_quad[0] ? (DEPTH_W - w_idx) : w_idx;

    assign w_first_half = !i_phase[PHASE_BITS-1];
    assign w_u          = i_phase[PHASE_BITS-1 -: 16];
    assign w_u4         = {1'b0, w_u, 2'b00};
    assign w_u2         = {2'b00, w_u, 1'b0};

    always_comb begin
        if (i_wave_sel == WAVE_TRIANGLE) begin
            w_t = w_u[15] ? (19'sd196608 - $signed(w_u4)) : ($signed(w_u4) - 19'sd65536);
        end else begin
            w_t = w_u[15] ? ($signed(w_u2) - 19'sd131072) : $signed(w_u2);
        end
    end

    assign w_tmag   = w_t[18] ? 17'(-w_t) : 17'(w_t);
    assign w_scaled = {w_tmag, 15'b0} - 32'(w_tmag);

    always_comb begin
        unique case (i_wave_sel)
            WAVE_SINE: begin
                o_wave.neg = w_quad[1];
                o_wave.mag = i_rom_data;
            end
            WAVE_SQUARE: begin
                o_wave.neg = !w_first_half && !i_unipolar;
                o_wave.mag = (w_first_half || !i_unipolar) ? 15'd32767 : 15'd0;
            end
            default: begin
                o_wave.neg = w_t[18];
                o_wave.mag = w_scaled[30:16];
            end
        endcase
    end

endmodule

// File: sv/sdnco_dp.sv
module sdnco_dp #(
    parameter int PHASE_BITS       = 32,
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sdnco_pkg::t_cfg    i_cfg,
    input  sdnco_pkg::t_cmd    i_cmd,
    input  logic               i_restart,
    output logic signed [15:0] o_left,
    output logic signed [15:0] o_right,
    output logic               o_last
);
    import sdnco_pkg::*;

    localparam int IW = $clog2(SINE_TABLE_DEPTH + 1);

    logic [PHASE_BITS-1:0] r_left_phase;
    logic [PHASE_BITS-1:0] r_right_phase;
    logic [25:0]           r_pos;
    logic [14:0]           r_rom_l;
    logic [14:0]           r_rom_r;
    logic [16:0]           r_gin;
    logic [16:0]           r_gout;
    logic                  r_fin;
    logic                  r_fout;
    logic                  r_last;
    logic [14:0]           r_mag_l;
    logic [14:0]           r_mag_r;
    logic                  r_neg_l;
    logic                  r_neg_r;
    logic signed [15:0]    r_out_l;
    logic signed [15:0]    r_out_r;
    logic                  r_out_last;

    logic [14:0]    w_rom [0:SINE_TABLE_DEPTH];
    logic [IW-1:0]  w_addr_l;
    logic [IW-1:0]  w_addr_r;
    t_wave          w_wave_l;
    t_wave          w_wave_r;
    logic           w_iso;
    logic           w_gate;
    logic [14:0]    w_am_l;
    logic [14:0]    w_am_r;
    logic           w_an_r;
    logic [15:0]    w_amp_sat;
    logic           w_pos_lt_loop;
    logic [25:0]    w_remain;
    logic [15:0]    w_a_l;
    logic [15:0]    w_a_r;
    logic [16:0]    w_b_l;
    logic [16:0]    w_b_r;
    logic [32:0]    w_prod_l;
    logic [32:0]    w_prod_r;
    logic [14:0]    w_fm_l;
    logic [14:0]    w_fm_r;
    logic signed [15:0] w_sl;
    logic signed [15:0] w_sr;

    function automatic logic [16:0] sat_gain(input logic [32:0] p);
        return (p > 33'd65536) ? 17'h10000 : p[16:0];
    endfunction

    for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_rom
        localparam longint unsigned X = (HALF_PI_Q30 * k) / SINE_TABLE_DEPTH;
        assign w_rom[k] = sine_entry(X);
    end

    always_ff @(posedge i_clk) begin
        r_rom_l <= w_rom[w_addr_l];
        r_rom_r <= w_rom[w_addr_r];
    end

    sdnco_wave #(
        .PHASE_BITS       (PHASE_BITS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_wave_l (
        .i_phase    (r_left_phase),
        .i_wave_sel (i_cfg.wave_sel),
        .i_unipolar (i_cfg.tone_mode),
        .i_rom_data (r_rom_l),
        .o_rom_addr (w_addr_l),
        .o_wave     (w_wave_l)
    );

    sdnco_wave #(
        .PHASE_BITS       (PHASE_BITS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_wave_r (
        .i_phase    (r_right_phase),
        .i_wave_sel (i_cfg.wave_sel),
        .i_unipolar (1'b0),
        .i_rom_data (r_rom_r),
        .o_rom_addr (w_addr_r),
        .o_wave     (w_wave_r)
    );

    assign w_iso     = i_cfg.tone_mode;
    assign w_gate    = !r_right_phase[PHASE_BITS-1];
    assign w_am_l    = (!w_iso || w_gate) ? w_wave_l.mag : 15'd0;
    assign w_am_r    = w_iso ? w_am_l : w_wave_r.mag;
    assign w_an_r    = w_iso ? w_wave_l.neg : w_wave_r.neg;
    assign w_amp_sat = (i_cfg.amplitude > 16'h8000) ? 16'h8000 : i_cfg.amplitude;

    assign w_pos_lt_loop = r_pos < i_cfg.loop_frames;
    assign w_remain      = w_pos_lt_loop ? (i_cfg.loop_frames - r_pos) : 26'd1;

    always_comb begin
        unique case (i_cmd.op) inside
            OP_GAIN: begin
                w_a_l = r_pos[15:0];
                w_a_r = w_remain[15:0];
                w_b_l = i_cfg.fade_step;
                w_b_r = i_cfg.fade_step;
            end
            OP_AMP: begin
                w_a_l = {1'b0, w_am_l};
                w_a_r = {1'b0, w_am_r};
                w_b_l = {1'b0, w_amp_sat};
                w_b_r = {1'b0, w_amp_sat};
            end
            OP_FIN, OP_FOUT: begin
                w_a_l = {1'b0, r_mag_l};
                w_a_r = {1'b0, r_mag_r};
                w_b_l = (i_cmd.op == OP_FIN) ? r_gin : r_gout;
                w_b_r = (i_cmd.op == OP_FIN) ? r_gin : r_gout;
            end
            default: begin
                w_a_l = 16'd0;
                w_a_r = 16'd0;
                w_b_l = 17'd0;
                w_b_r = 17'd0;
            end
        endcase
    end

    assign w_prod_l = 33'(w_a_l) * 33'(w_b_l);
    assign w_prod_r = 33'(w_a_r) * 33'(w_b_r);

    assign w_fm_l = r_fout ? w_prod_l[30:16] : r_mag_l;
    assign w_fm_r = r_fout ? w_prod_r[30:16] : r_mag_r;
    assign w_sl   = $signed({1'b0, w_fm_l});
    assign w_sr   = $signed({1'b0, w_fm_r});

    always_ff @(posedge i_clk) begin
        if (i_cmd.run) begin
            unique case (i_cmd.op)
                OP_GAIN: begin
                    r_gin  <= sat_gain(w_prod_l);
                    r_gout <= sat_gain(w_prod_r);
                    r_fin  <= r_pos < {10'd0, i_cfg.fade_frames};
                    r_fout <= w_remain <= {10'd0, i_cfg.fade_frames};
                    r_last <= ({1'b0, r_pos} + 27'd1) >= {1'b0, i_cfg.loop_frames};
                end
                OP_AMP: begin
                    r_mag_l <= w_prod_l[29:15];
                    r_mag_r <= w_prod_r[29:15];
                    r_neg_l <= w_wave_l.neg;
                    r_neg_r <= w_an_r;
                end
                OP_FIN: begin
                    if (r_fin) begin
                        r_mag_l <= w_prod_l[30:16];
                        r_mag_r <= w_prod_r[30:16];
                    end
                end
                OP_FOUT: begin
                    if (i_cmd.finish) begin
                        r_out_l    <= r_neg_l ? -w_sl : w_sl;
                        r_out_r    <= r_neg_r ? -w_sr : w_sr;
                        r_out_last <= r_last;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_phase  <= '0;
            r_right_phase <= '0;
            r_pos         <= '0;
        end else if (i_cmd.load && i_restart) begin
            r_left_phase  <= '0;
            r_right_phase <= '0;
            r_pos         <= '0;
        end else if (i_cmd.finish) begin
            if (r_last) begin
                r_left_phase  <= '0;
                r_right_phase <= '0;
                r_pos         <= '0;
            end else begin
                r_left_phase  <= r_left_phase + PHASE_BITS'(i_cfg.left_step);
                r_right_phase <= r_right_phase + PHASE_BITS'(i_cfg.right_step);
                r_pos         <= r_pos + 26'd1;
            end
        end
    end

    assign o_left  = r_out_l;
    assign o_right = r_out_r;
    assign o_last  = r_out_last;

endmodule

// File: sv/stereo_dual_nco_tone_generator_top.sv
// Stereo dual-NCO tone generator. Each word on the slave stream is one sample tick
// (bit 0 = restart) and yields one stereo frame on the master stream, with tlast
// marking the last frame of the loop. A frame goes from acceptance to the output
// register in one step each for the fade gains, the amplitude, the fade-in and
// the fade-out, run through one 16x17 multiplier per channel; the next word is
// taken in the cycle the result is stored, so no word is taken while an earlier
// frame is in its steps. The output register holds a frame while the sink stalls;
// the last step waits on it. Configuration is always ready and must only be written
// while no frame is in flight. The sine table is a constant quarter-wave ROM built
// at elaboration, so no clearing pass follows reset.
`include "stereo_dual_nco_tone_generator_top_macros.svh"

module stereo_dual_nco_tone_generator_top #(
    parameter int PHASE_BITS       = 32,
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,  // [0] restart
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [31:0]                       m_axis_tdata,  // [15:0] left_sample,
                                                             // [31:16] right_sample
    output logic                              m_axis_tlast,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [sdnco_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [sdnco_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import sdnco_pkg::*;

    t_cfg               w_cfg;
    t_cmd               w_cmd;
    logic signed [15:0] w_left;
    logic signed [15:0] w_right;

    assign o_cfg_ready = 1'b1;

    sdnco_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    sdnco_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (w_cmd)
    );

    sdnco_dp #(
        .PHASE_BITS       (PHASE_BITS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_cmd     (w_cmd),
        .i_restart (s_axis_tdata[0]),
        .o_left    (w_left),
        .o_right   (w_right),
        .o_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {w_right, w_left};

    `SDNCO_ASSERT_NXT(a_accept_starts_gain, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, w_cmd.run && (w_cmd.op == OP_GAIN))
    `SDNCO_ASSERT_NXT(a_finish_shows_result, i_clk, i_rst_n, w_cmd.finish, m_axis_tvalid)
    `SDNCO_ASSERT_IMP(a_accept_only_when_free, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !w_cmd.run || w_cmd.finish)

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps

module testbench;

    import sdnco_pkg::*;

    typedef struct packed {
        logic [15:0] left;
        logic [15:0] right;
        logic        last;
    } t_tone_frame;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_valid = 1'b0;
    logic [7:0]             s_data = '0;
    logic                   m_tready = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   s_axis_tready;
    logic                   m_axis_tvalid;
    logic [31:0]            m_axis_tdata;
    logic                   m_axis_tlast;
    logic                   o_cfg_ready;

    int          quarter_wave [0:1024];
    t_cfg        tone_cfg = CFG_RESET;
    logic [31:0] left_acc = '0;
    logic [31:0] right_acc = '0;
    logic [25:0] frame_pos = '0;
    t_tone_frame frames_due [$];
    int          mismatches = 0;
    bit          calm = 1'b0;

    stereo_dual_nco_tone_generator_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #2000000;
        $display("[stereo_dual_nco_tone_generator_top] ERROR");
        $finish;
    end

    function automatic void build_quarter_wave();
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned v;
        longint          acc;
        for (int k = 0; k <= 1024; k++) begin
            x    = (HALF_PI_Q30 * longint'(k)) / 1024;
            x2   = (x * x) >> 30;
            term = x;
            acc  = longint'(x);
            for (int n = 1; n <= 8; n++) begin
                term = (term * x2) >> 30;
                term = term / longint'((2 * n) * (2 * n + 1));
                if (n % 2 == 1) begin
                    acc = acc - longint'(term);
                end else begin
                    acc = acc + longint'(term);
                end
            end
            if (acc < 0) begin
                acc = 0;
            end
            v = (longint'(acc) * 32767 + (64'd1 << 29)) >> 30;
            if (v > 32767) begin
                v = 32767;
            end
            quarter_wave[k] = int'(v);
        end
    endfunction

    function automatic int ramp_scale(longint t);
        longint mag;
        longint r;
        mag = (t < 0) ? -t : t;
        r   = (mag * 32767) >> 16;
        return int'((t < 0) ? -r : r);
    endfunction

    function automatic int gain_of(int s, longint g, int shift);
        longint mag;
        longint r;
        mag = (s < 0) ? -longint'(s) : longint'(s);
        r   = (mag * g) >> shift;
        return int'((s < 0) ? -r : r);
    endfunction

    function automatic int wave_of(logic [31:0] p, bit unipolar);
        longint u;
        int     v;
        u = longint'(p[31:16]);
        case (tone_cfg.wave_sel)
            WAVE_SQUARE: begin
                return !p[31] ? 32767 : (unipolar ? 0 : -32767);
            end
            WAVE_TRIANGLE: begin
                return ramp_scale((u < 32768) ? 4 * u - 65536 : 196608 - 4 * u);
            end
            WAVE_SAWTOOTH: begin
                return ramp_scale((u < 32768) ? 2 * u : 2 * u - 131072);
            end
            default: begin
                v = p[30] ? quarter_wave[1024 - int'(p[29:20])] : quarter_wave[p[29:20]];
                return p[31] ? -v : v;
            end
        endcase
    endfunction

    function automatic t_tone_frame compute_frame(bit restart);
        t_tone_frame f;
        longint      amp;
        longint      remain;
        longint      g;
        int          left;
        int          right;
        bit          last;
        if (restart) begin
            left_acc  = '0;
            right_acc = '0;
            frame_pos = '0;
        end
        amp = (tone_cfg.amplitude > 32768) ? 32768 : longint'(tone_cfg.amplitude);
        if (tone_cfg.tone_mode) begin
            left  = !right_acc[31] ? gain_of(wave_of(left_acc, 1'b1), amp, 15) : 0;
            right = left;
        end else begin
            left  = gain_of(wave_of(left_acc, 1'b0), amp, 15);
            right = gain_of(wave_of(right_acc, 1'b0), amp, 15);
        end
        remain = (frame_pos < tone_cfg.loop_frames) ?
                 longint'(tone_cfg.loop_frames) - longint'(frame_pos) : 1;
        if (frame_pos < tone_cfg.fade_frames) begin
            g = longint'(frame_pos) * longint'(tone_cfg.fade_step);
            if (g > 65536) g = 65536;
            left  = gain_of(left, g, 16);
            right = gain_of(right, g, 16);
        end
        if (remain <= longint'(tone_cfg.fade_frames)) begin
            g = remain * longint'(tone_cfg.fade_step);
            if (g > 65536) g = 65536;
            left  = gain_of(left, g, 16);
            right = gain_of(right, g, 16);
        end
        last    = (longint'(frame_pos) + 1 >= longint'(tone_cfg.loop_frames));
        f.left  = left[15:0];
        f.right = right[15:0];
        f.last  = last;
        if (last) begin
            left_acc  = '0;
            right_acc = '0;
            frame_pos = '0;
        end else begin
            left_acc  = left_acc + {1'b0, tone_cfg.left_step};
            right_acc = right_acc + {1'b0, tone_cfg.right_step};
            frame_pos = frame_pos + 26'd1;
        end
        return f;
    endfunction

    function automatic void apply_setting(logic [CFG_INDEX_W-1:0] index,
                                          logic [CFG_DATA_W-1:0] value);
        case (index)
            CFG_LEFT_STEP:   tone_cfg.left_step   = value[30:0];
            CFG_RIGHT_STEP:  tone_cfg.right_step  = value[30:0];
            CFG_WAVE_SEL:    tone_cfg.wave_sel    = value[1:0];
            CFG_TONE_MODE:   tone_cfg.tone_mode   = value[0];
            CFG_AMPLITUDE:   tone_cfg.amplitude   = value[15:0];
            CFG_LOOP_FRAMES: tone_cfg.loop_frames = value[25:0];
            CFG_FADE_FRAMES: tone_cfg.fade_frames = value[15:0];
            CFG_FADE_STEP:   tone_cfg.fade_step   = value[16:0];
            default: ;
        endcase
    endfunction

    task automatic flag_mismatch(string what, longint want, longint got);
        $display("mismatch at %0t: %s, expected %0d, got %0d", $realtime, what, want, got);
        mismatches++;
    endtask

    always @(negedge i_clk) begin
        m_tready <= calm || ($urandom_range(99) >= 15);
    end

    always @(posedge i_clk) begin
        t_tone_frame want;
        if (i_rst_n && m_axis_tvalid && m_tready) begin
            if (frames_due.size() == 0) begin
                flag_mismatch("frame with none due", 0, 1);
            end else begin
                want = frames_due.pop_front();
                if (m_axis_tdata[15:0] !== want.left) begin
                    flag_mismatch("left_sample", longint'($signed(want.left)),
                                  longint'($signed(m_axis_tdata[15:0])));
                end
                if (m_axis_tdata[31:16] !== want.right) begin
                    flag_mismatch("right_sample", longint'($signed(want.right)),
                                  longint'($signed(m_axis_tdata[31:16])));
                end
                if (m_axis_tlast !== want.last) begin
                    flag_mismatch("loop_end", want.last, m_axis_tlast);
                end
            end
        end
    end

    task automatic send_tick(bit restart);
        int gap;
        @(negedge i_clk);
        if (!calm && $urandom_range(99) < 15) begin
            gap = $urandom_range(4, 1);
            s_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_valid = 1'b1;
        s_data  = {7'd0, restart};
        do @(posedge i_clk); while (!s_axis_tready);
        frames_due.push_back(compute_frame(restart));
    endtask

    task automatic write_setting(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        s_valid = 1'b0;
        while (frames_due.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
        cfg_valid = 1'b1;
        cfg_index = index;
        cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_setting(index, value);
        @(negedge i_clk);
        cfg_valid = 1'b0;
    endtask

    task automatic test_reset_defaults();
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b1);
    endtask

    task automatic test_waveforms();
        write_setting(CFG_FADE_FRAMES, 31'd0);
        write_setting(CFG_AMPLITUDE, 31'd65535);
        write_setting(CFG_LOOP_FRAMES, 31'd67108863);
        write_setting(CFG_LEFT_STEP, 31'h2000_0000);
        write_setting(CFG_RIGHT_STEP, 31'h7FFF_FFFF);
        for (int w = 0; w < 4; w++) begin
            write_setting(CFG_WAVE_SEL, 31'(w));
            send_tick(1'b1);
            send_tick(1'b0);
        end
    endtask

    task automatic test_isochronic();
        write_setting(CFG_TONE_MODE, 31'd1);
        write_setting(CFG_WAVE_SEL, 31'(WAVE_SQUARE));
        write_setting(CFG_AMPLITUDE, 31'd32768);
        write_setting(CFG_LEFT_STEP, 31'h5000_0000);
        write_setting(CFG_RIGHT_STEP, 31'h6000_0000);
        send_tick(1'b1);
        repeat (3) send_tick(1'b0);
    endtask

    task automatic test_loop_edges();
        write_setting(CFG_TONE_MODE, 31'd0);
        write_setting(CFG_WAVE_SEL, 31'(WAVE_TRIANGLE));
        write_setting(CFG_LOOP_FRAMES, 31'd0);
        repeat (2) send_tick(1'b0);
        write_setting(CFG_LOOP_FRAMES, 31'd3);
        write_setting(CFG_FADE_FRAMES, 31'd2);
        write_setting(CFG_FADE_STEP, 31'd65536);
        repeat (4) send_tick(1'b0);
        write_setting(CFG_LOOP_FRAMES, 31'd10);
        write_setting(CFG_FADE_FRAMES, 31'd0);
        repeat (4) send_tick(1'b0);
        // shrink the loop below the current position
        write_setting(CFG_LOOP_FRAMES, 31'd2);
        send_tick(1'b0);
    endtask

    task automatic randomize_settings();
        int loop_len;
        int fade_len;
        int step;
        case ($urandom_range(7))
            0:       write_setting(CFG_LEFT_STEP, 31'd0);
            1:       write_setting(CFG_LEFT_STEP, 31'h7FFF_FFFF);
            2:       write_setting(CFG_LEFT_STEP, 31'($urandom_range(65535)));
            default: write_setting(CFG_LEFT_STEP, 31'($urandom));
        endcase
        case ($urandom_range(7))
            0:       write_setting(CFG_RIGHT_STEP, 31'd0);
            1:       write_setting(CFG_RIGHT_STEP, 31'h7FFF_FFFF);
            default: write_setting(CFG_RIGHT_STEP, 31'($urandom));
        endcase
        write_setting(CFG_WAVE_SEL, 31'($urandom_range(3)));
        write_setting(CFG_TONE_MODE, 31'($urandom_range(1)));
        case ($urandom_range(9))
            0:       write_setting(CFG_AMPLITUDE, 31'd0);
            1:       write_setting(CFG_AMPLITUDE, 31'd32768);
            2:       write_setting(CFG_AMPLITUDE, 31'($urandom_range(65535, 32769)));
            default: write_setting(CFG_AMPLITUDE, 31'($urandom_range(32768)));
        endcase
        case ($urandom_range(9))
            0:       loop_len = 0;
            1:       loop_len = 1;
            2:       loop_len = $urandom_range(67108863);
            default: loop_len = $urandom_range(150, 2);
        endcase
        write_setting(CFG_LOOP_FRAMES, 31'(loop_len));
        case ($urandom_range(9))
            0:       fade_len = 0;
            1:       fade_len = 65535;
            default: fade_len = $urandom_range((loop_len > 120) ? 60 : loop_len / 2 + 1);
        endcase
        write_setting(CFG_FADE_FRAMES, 31'(fade_len));
        case ($urandom_range(5))
            0:       step = 65536;
            1:       step = $urandom_range(65536);
            default: step = (fade_len == 0) ? 0 : (65536 + fade_len - 1) / fade_len;
        endcase
        write_setting(CFG_FADE_STEP, 31'(step));
    endtask

    task automatic test_random_streams();
        for (int phase = 0; phase < 20; phase++) begin
            calm = (phase >= 8 && phase < 12);
            randomize_settings();
            repeat (100) send_tick($urandom_range(99) < 3);
        end
        calm = 1'b0;
    endtask

    initial begin
        build_quarter_wave();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_waveforms();
        test_isochronic();
        test_loop_edges();
        test_random_streams();

        @(negedge i_clk);
        s_valid = 1'b0;
        while (frames_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("[stereo_dual_nco_tone_generator_top] OK");
        end else begin
            $display("[stereo_dual_nco_tone_generator_top] ERROR");
        end
        $finish;
    end

endmodule
